/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the valve controller modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// post must hold in the cycle after pre
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* hw/rtl/tpvac_pkg.sv */
// Package with the shared types and constants of the valve actuator controller.
`timescale 1ns / 1ps

package tpvac_pkg;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;
   localparam int ACT_W      = 3;
   localparam int ELAPSED_W  = 16;
   localparam int DEMAND_W   = 11;
   localparam int POS_W      = 22;
   localparam int MODE_W     = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 20;
   localparam int DIV_STEPS  = 40;
   localparam int DIV_CNT_W  = 6;
   localparam int STEP_LIMIT = 32;
   localparam int STEP_CNT_W = 5;

   localparam int SWITCH_PAUSE_MS = 500;
   localparam int OVERDRIVE_MS    = 4000;
   localparam int MAX_TICK_MS     = 255;
   localparam int WAIT_MAX        = 2097151;
   localparam int POS_MAX         = 2097151;
   localparam int POS_MIN         = -2097152;

   localparam logic [ACT_W-1:0] ACT_TICK   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_DEMAND = 3'd1;
   localparam logic [ACT_W-1:0] ACT_RESET  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_FULL   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_FORCE  = 3'd4;
   localparam logic [ACT_W-1:0] ACT_STOP   = 3'd5;

   localparam logic [MODE_W-1:0] MODE_INIT   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_NORMAL = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RESET  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FULL   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FORCE  = 3'd4;

   localparam logic [CSR_ADDR_W-1:0] CSR_FULL_TRAVEL = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_OPEN    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_RUN     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_RUN     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAUSE       = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_RUN_CORR    = 3'd5;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_MULA_TICK,
      OP_MULA_WANT,
      OP_MULB,
      OP_DIV,
      OP_APPLY,
      OP_STEP
   } op_type;

   typedef struct packed {
      op_type op;
      logic   accept;
      logic   load_rsp;
   } cmd_type;

   typedef struct packed {
      logic demand_nz;
      logic need_want;
      logic step_done;
   } status_type;

endpackage

/* hw/rtl/tpvac_ctrl.sv */
// Sequencer that steps the datapath through events, ticks and section steps.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpvac_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  item_tick,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  tpvac_pkg::status_type status,
   output tpvac_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_TMULA, S_TMULB, S_TDIV, S_APPLY, S_STEP,
      S_WMULA, S_WMULB, S_WDIV, S_WSTEP, S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic [tpvac_pkg::STEP_CNT_W-1:0] step_cnt_ff, step_cnt_in;
   logic [tpvac_pkg::DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic step_last;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign step_last  = status.step_done
                       || (step_cnt_ff == tpvac_pkg::STEP_CNT_W'(tpvac_pkg::STEP_LIMIT - 1));

   always_comb begin
      state_in     = state_ff;
      step_cnt_in  = step_cnt_ff;
      div_cnt_in   = div_cnt_ff;
      cmd.op       = tpvac_pkg::OP_NOP;
      cmd.accept   = 1'b0;
      cmd.load_rsp = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.accept = req_tvalid;
            if (req_tvalid) begin
               if (!item_tick) begin
                  state_in = S_FINISH;
               end else if (status.demand_nz) begin
                  state_in = S_TMULA;
               end else begin
                  state_in = S_APPLY;
               end
            end
         end
         S_TMULA: begin
            cmd.op   = tpvac_pkg::OP_MULA_TICK;
            state_in = S_TMULB;
         end
         S_TMULB: begin
            cmd.op     = tpvac_pkg::OP_MULB;
            div_cnt_in = '0;
            state_in   = S_TDIV;
         end
         S_TDIV: begin
            cmd.op     = tpvac_pkg::OP_DIV;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == tpvac_pkg::DIV_CNT_W'(tpvac_pkg::DIV_STEPS - 1)) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            cmd.op      = tpvac_pkg::OP_APPLY;
            step_cnt_in = '0;
            state_in    = S_STEP;
         end
         S_STEP: begin
            if (status.need_want) begin
               state_in = S_WMULA;
            end else begin
               cmd.op = tpvac_pkg::OP_STEP;
               if (step_last) begin
                  state_in = S_FINISH;
               end else begin
                  step_cnt_in = step_cnt_ff + 1'b1;
               end
            end
         end
         S_WMULA: begin
            cmd.op   = tpvac_pkg::OP_MULA_WANT;
            state_in = S_WMULB;
         end
         S_WMULB: begin
            cmd.op     = tpvac_pkg::OP_MULB;
            div_cnt_in = '0;
            state_in   = S_WDIV;
         end
         S_WDIV: begin
            cmd.op     = tpvac_pkg::OP_DIV;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == tpvac_pkg::DIV_CNT_W'(tpvac_pkg::DIV_STEPS - 1)) begin
               state_in = S_WSTEP;
            end
         end
         S_WSTEP: begin
            cmd.op = tpvac_pkg::OP_STEP;
            if (step_last) begin
               state_in = S_FINISH;
            end else begin
               step_cnt_in = step_cnt_ff + 1'b1;
               state_in    = S_STEP;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_cnt_ff  <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_cnt_ff  <= step_cnt_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "ready right after accept")
   `ASSERT_NEXT(a_load_sets_valid, clock, reset, cmd.load_rsp, rsp_tvalid, "loaded result not shown")

endmodule

/* hw/rtl/tpvac_dp.sv */
// Datapath: settings, valve state, multiplier, divider and section step logic.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpvac_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [tpvac_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [tpvac_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [tpvac_pkg::ACT_W-1:0]          req_action,
   input  logic [tpvac_pkg::ELAPSED_W-1:0]      req_elapsed_ms,
   input  logic signed [tpvac_pkg::DEMAND_W-1:0] req_demand,
   input  logic                                 req_move_up,
   input  tpvac_pkg::cmd_type                   cmd,
   output tpvac_pkg::status_type                status,
   output logic [tpvac_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   typedef struct packed {
      logic signed [1:0] exp_dir;
      logic signed [1:0] act_dir;
      logic              clr;
      logic              ok;
   } sd_type;

   function automatic logic signed [1:0] real_dir(input logic signed [1:0] a,
                                                 input logic signed [1:0] e);
      if (e == 2'sd0 || (a != 2'sd0 && a != e)) begin
         return 2'sd0;
      end
      return e;
   endfunction

   function automatic sd_type set_dir(input logic signed [1:0] d,
                                      input logic signed [1:0] e,
                                      input logic signed [1:0] a,
                                      input logic r);
      sd_type s;
      s.exp_dir = e;
      s.act_dir = a;
      s.clr     = 1'b0;
      s.ok      = (d == a);
      if (d != e) begin
         s.exp_dir = d;
         if (r && d != a) begin
            s.clr     = 1'b1;
            s.act_dir = real_dir(a, d);
         end
         s.ok = (s.act_dir == d);
      end
      return s;
   endfunction

   // settings
   logic [19:0]        full_ff;
   logic [18:0]        min_open_ff;
   logic [15:0]        min_run_ff;
   logic [13:0]        max_run_ff;
   logic [15:0]        pause_ff;
   logic signed [16:0] corr_ff;

   // valve state
   logic [2:0]         mode_ff, mode_in;
   logic [2:0]         phase_ff, phase_in;
   logic               req_dir_ff, req_dir_in;
   logic signed [1:0]  exp_ff, exp_in, act_ff, act_in;
   logic [31:0]        se_ff, se_in;
   logic [20:0]        wait_ff, wait_in;
   logic [14:0]        run_ff, run_in;
   logic signed [31:0] tps_ff, tps_in;
   logic signed [10:0] dem_ff, dem_in;
   logic signed [21:0] real_ff, real_in;
   logic [31:0]        work_ff, work_in;
   logic               saved_valid_ff, saved_valid_in;
   logic [2:0]         saved_mode_ff, saved_mode_in;
   logic               saved_dir_ff, saved_dir_in;

   // arithmetic units
   logic [15:0]        raw_ff;
   logic [29:0]        m1_ff;
   logic [39:0]        quo_ff, quo_in;
   logic [16:0]        rem_ff, rem_in;
   logic [31:0]        rsp_ff;

   localparam logic [2:0] PH_START = 3'd0;
   localparam logic [2:0] PH_HOLD  = 3'd1;
   localparam logic [2:0] PH_REQ   = 3'd2;
   localparam logic [2:0] PH_ON    = 3'd3;
   localparam logic [2:0] PH_TIMER = 3'd4;
   localparam logic [2:0] PH_RUN   = 3'd5;
   localparam logic [2:0] PH_OVER  = 3'd6;
   localparam logic [2:0] PH_BACK  = 3'd7;

   logic               rdy, step_done;
   logic signed [1:0]  d_req, want;
   logic signed [21:0] upper, min_open_s;
   logic signed [31:0] lo_tps, hi_tps;
   logic [16:0]        div_sum, divisor;
   logic [18:0]        lim_thr;
   logic [15:0]        lim, mul_b;
   logic signed [10:0] dem_abs;
   logic [7:0]         td;
   logic [29:0]        m1_prod;
   logic [39:0]        mb_prod;
   logic [17:0]        shl, shl_sub;
   logic signed [33:0] q_pos, q_s, pred, pred_abs, pred_qa, pred_q;
   logic signed [34:0] wdiff, lim_s;
   logic               want_up, want_dn, need_want;
   logic [32:0]        se_sum, work_sum;
   logic [31:0]        se_tick;
   logic signed [33:0] tps_sum;
   logic signed [23:0] rt_sum, rc_sum, real24, td24, corr24;
   logic signed [21:0] hv, hv2, end_pos;
   logic [16:0]        e8;
   logic [20:0]        fw;
   logic signed [24:0] nf, w25;
   logic signed [33:0] sr_diff;
   logic [23:0]        full10;
   logic               stop, resync;
   sd_type             sd0, sdd, sdn;

   assign rdy        = se_ff >= 32'(tpvac_pkg::SWITCH_PAUSE_MS);
   assign d_req      = req_dir_ff ? 2'sd1 : -2'sd1;
   assign min_open_s = $signed({3'b000, min_open_ff});
   assign upper      = $signed({2'b00, full_ff}) - min_open_s;
   assign lo_tps     = $signed({5'b0, min_open_ff, 8'b0});
   assign hi_tps     = $signed({{2{upper[21]}}, upper, 8'b0});
   assign div_sum    = {1'b0, pause_ff} + {3'b000, max_run_ff};
   assign divisor    = (div_sum == '0) ? 17'd1 : div_sum;
   assign lim_thr    = {2'b00, pause_ff, 1'b0} + {5'b0, max_run_ff}
                       + 19'(tpvac_pkg::SWITCH_PAUSE_MS);
   assign lim        = (se_ff < {13'b0, lim_thr}) ? {2'b00, max_run_ff} : min_run_ff;
   assign dem_abs    = dem_ff[10] ? -dem_ff : dem_ff;
   assign td         = (raw_ff > 16'(tpvac_pkg::MAX_TICK_MS))
                       ? 8'(tpvac_pkg::MAX_TICK_MS) : raw_ff[7:0];

   assign mul_b   = (cmd.op == tpvac_pkg::OP_MULA_TICK) ? {8'b0, td} : lim;
   assign m1_prod = {16'b0, max_run_ff} * {14'b0, mul_b};
   assign mb_prod = {30'b0, dem_abs[9:0]} * {10'b0, m1_ff};
   assign shl     = {rem_ff, quo_ff[39]};
   assign shl_sub = shl - {1'b0, divisor};

   assign q_pos    = $signed({2'b00, quo_ff[31:0]});
   assign q_s      = dem_ff[10] ? -q_pos : q_pos;
   assign pred     = $signed({{2{tps_ff[31]}}, tps_ff}) + q_s;
   assign pred_abs = pred[33] ? -pred : pred;
   assign pred_qa  = pred_abs >>> 8;
   assign pred_q   = pred[33] ? -pred_qa : pred_qa;
   assign wdiff    = $signed({pred_q[33], pred_q}) - $signed({{13{real_ff[21]}}, real_ff});
   assign lim_s    = $signed({19'b0, lim});
   assign want_up  = !dem_ff[10] && (dem_ff != 11'sd0) && (wdiff > lim_s);
   assign want_dn  = dem_ff[10] && (wdiff < -lim_s);
   assign need_want = (phase_ff == PH_REQ) && (dem_ff != 11'sd0) && rdy;
   assign want     = !need_want ? 2'sd0 : (want_up ? 2'sd1 : (want_dn ? -2'sd1 : 2'sd0));

   assign se_sum   = {1'b0, se_ff} + {17'b0, raw_ff};
   assign se_tick  = se_sum[32] ? '1 : se_sum[31:0];
   assign tps_sum  = $signed({{2{tps_ff[31]}}, tps_ff}) + q_s;
   assign real24   = $signed({{2{real_ff[21]}}, real_ff});
   assign td24     = $signed({16'b0, td});
   assign rt_sum   = (act_ff > 2'sd0) ? real24 + td24 : real24 - td24;
   assign work_sum = {1'b0, work_ff} + {25'b0, td};

   assign sd0 = set_dir(2'sd0, exp_ff, act_ff, rdy);
   assign sdd = set_dir(d_req, exp_ff, act_ff, rdy);
   assign sdn = set_dir(-d_req, exp_ff, act_ff, rdy);

   assign hv      = (real_ff < upper) ? real_ff : upper;
   assign hv2     = (hv < min_open_s) ? min_open_s : hv;
   assign e8      = full_ff[19:3];
   assign fw      = {1'b0, full_ff}
                    + ((e8 > 17'(tpvac_pkg::OVERDRIVE_MS)) ? {4'b0, e8}
                                                           : 21'(tpvac_pkg::OVERDRIVE_MS));
   assign nf      = (d_req < 2'sd0) ? $signed({{3{real_ff[21]}}, real_ff})
                    : $signed({5'b0, full_ff}) - $signed({{3{real_ff[21]}}, real_ff});
   assign w25     = nf + 25'sd4000;
   assign end_pos = (d_req < 2'sd0) ? min_open_s : upper;
   assign sr_diff = $signed({{2{tps_ff[31]}}, tps_ff}) - $signed({{4{real_ff[21]}}, real_ff, 8'b0});
   assign stop    = ((d_req < 2'sd0) && (sr_diff >= 34'sd0))
                    || ((d_req > 2'sd0) && (sr_diff <= 34'sd0));
   assign full10  = {1'b0, full_ff, 3'b000} + {3'b000, full_ff, 1'b0};
   assign resync  = (work_ff >= {8'b0, full10})
                    && (((d_req < 2'sd0) && (tps_ff == lo_tps))
                        || ((d_req > 2'sd0) && (tps_ff == hi_tps)));
   assign corr24  = $signed({{7{corr_ff[16]}}, corr_ff});
   assign rc_sum  = (d_req > 2'sd0) ? real24 + corr24 : real24 - corr24;

   always_comb begin
      mode_in        = mode_ff;
      phase_in       = phase_ff;
      req_dir_in     = req_dir_ff;
      exp_in         = exp_ff;
      act_in         = act_ff;
      se_in          = se_ff;
      wait_in        = wait_ff;
      run_in         = run_ff;
      tps_in         = tps_ff;
      dem_in         = dem_ff;
      real_in        = real_ff;
      work_in        = work_ff;
      saved_valid_in = saved_valid_ff;
      saved_mode_in  = saved_mode_ff;
      saved_dir_in   = saved_dir_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      step_done      = 1'b0;

      if (cmd.accept) begin
         case (req_action)
            tpvac_pkg::ACT_DEMAND: begin
               if (req_demand < -11'sd512) begin
                  dem_in = -11'sd512;
               end else if (req_demand > 11'sd512) begin
                  dem_in = 11'sd512;
               end else begin
                  dem_in = req_demand;
               end
            end
            tpvac_pkg::ACT_RESET, tpvac_pkg::ACT_FULL, tpvac_pkg::ACT_STOP: begin
               if (saved_valid_ff) begin
                  mode_in        = saved_mode_ff;
                  req_dir_in     = saved_dir_ff;
                  phase_in       = PH_START;
                  saved_valid_in = 1'b0;
               end else if (req_action != tpvac_pkg::ACT_STOP) begin
                  mode_in    = (req_action == tpvac_pkg::ACT_RESET) ? tpvac_pkg::MODE_RESET
                                                                    : tpvac_pkg::MODE_FULL;
                  req_dir_in = req_move_up;
                  phase_in   = PH_START;
               end
            end
            tpvac_pkg::ACT_FORCE: begin
               if (!saved_valid_ff) begin
                  saved_valid_in = 1'b1;
                  saved_mode_in  = mode_ff;
                  saved_dir_in   = req_dir_ff;
                  mode_in        = tpvac_pkg::MODE_FORCE;
                  req_dir_in     = req_move_up;
               end
               phase_in = PH_START;
            end
            default: ;
         endcase
      end

      case (cmd.op)
         tpvac_pkg::OP_MULB: begin
            quo_in = mb_prod;
            rem_in = '0;
         end
         tpvac_pkg::OP_DIV: begin
            if (shl >= {1'b0, divisor}) begin
               rem_in = shl_sub[16:0];
               quo_in = {quo_ff[38:0], 1'b1};
            end else begin
               rem_in = shl[16:0];
               quo_in = {quo_ff[38:0], 1'b0};
            end
         end
         tpvac_pkg::OP_APPLY: begin
            se_in   = se_tick;
            wait_in = (wait_ff > {5'b0, raw_ff}) ? wait_ff - {5'b0, raw_ff} : '0;
            run_in  = ({1'b0, run_ff} > raw_ff) ? run_ff - raw_ff[14:0] : '0;
            if (dem_ff != 11'sd0) begin
               if (tps_sum < $signed({{2{lo_tps[31]}}, lo_tps})) begin
                  tps_in = lo_tps;
               end else if (tps_sum > $signed({{2{hi_tps[31]}}, hi_tps})) begin
                  tps_in = hi_tps;
               end else begin
                  tps_in = tps_sum[31:0];
               end
            end
            if (act_ff != 2'sd0) begin
               if (rt_sum > 24'(tpvac_pkg::POS_MAX)) begin
                  real_in = 22'(tpvac_pkg::POS_MAX);
               end else if (rt_sum < 24'(tpvac_pkg::POS_MIN)) begin
                  real_in = 22'(tpvac_pkg::POS_MIN);
               end else begin
                  real_in = rt_sum[21:0];
               end
               work_in = work_sum[32] ? '1 : work_sum[31:0];
            end
            if (exp_ff != act_ff && se_tick >= 32'(tpvac_pkg::SWITCH_PAUSE_MS)) begin
               se_in  = '0;
               act_in = real_dir(act_ff, exp_ff);
            end
         end
         tpvac_pkg::OP_STEP: begin
            unique case (phase_ff)
               PH_START: begin
                  if (mode_ff == tpvac_pkg::MODE_INIT || mode_ff == tpvac_pkg::MODE_NORMAL) begin
                     req_dir_in = 1'b0;
                     exp_in     = sd0.exp_dir;
                     act_in     = sd0.act_dir;
                     if (sd0.clr) se_in = '0;
                     phase_in   = (mode_ff == tpvac_pkg::MODE_INIT) ? PH_HOLD : PH_REQ;
                     step_done  = (mode_ff == tpvac_pkg::MODE_INIT);
                  end else if (mode_ff == tpvac_pkg::MODE_FORCE) begin
                     exp_in   = sdd.exp_dir;
                     act_in   = sdd.act_dir;
                     if (sdd.clr) se_in = '0;
                     phase_in = PH_HOLD;
                  end else begin
                     phase_in = PH_ON;
                  end
               end
               PH_HOLD: begin
                  if (mode_ff == tpvac_pkg::MODE_FORCE) begin
                     tps_in = $signed({{2{hv2[21]}}, hv2, 8'b0});
                  end
                  step_done = 1'b1;
               end
               PH_REQ: begin
                  if (want == 2'sd0) begin
                     step_done = 1'b1;
                  end else begin
                     req_dir_in = (want > 2'sd0);
                     phase_in   = PH_ON;
                  end
               end
               PH_ON: begin
                  exp_in = sdd.exp_dir;
                  act_in = sdd.act_dir;
                  if (sdd.clr) se_in = '0;
                  if (!sdd.ok) begin
                     step_done = 1'b1;
                  end else if (mode_ff == tpvac_pkg::MODE_NORMAL) begin
                     wait_in  = {5'b0, min_run_ff};
                     phase_in = PH_TIMER;
                  end else begin
                     if (mode_ff == tpvac_pkg::MODE_FULL) begin
                        wait_in = fw;
                     end else if (w25 < 25'sd0) begin
                        wait_in = '0;
                     end else if (w25 > 25'(tpvac_pkg::WAIT_MAX)) begin
                        wait_in = 21'(tpvac_pkg::WAIT_MAX);
                     end else begin
                        wait_in = w25[20:0];
                     end
                     phase_in = PH_OVER;
                  end
               end
               PH_OVER: begin
                  if (wait_ff != '0) begin
                     step_done = 1'b1;
                  end else begin
                     phase_in = PH_BACK;
                  end
               end
               PH_BACK: begin
                  exp_in = sdn.exp_dir;
                  act_in = sdn.act_dir;
                  if (sdn.clr) se_in = '0;
                  if (!sdn.ok) begin
                     step_done = 1'b1;
                  end else begin
                     wait_in  = {2'b00, min_open_ff};
                     phase_in = PH_TIMER;
                  end
               end
               PH_TIMER: begin
                  if (wait_ff != '0) begin
                     step_done = 1'b1;
                  end else if (mode_ff == tpvac_pkg::MODE_NORMAL) begin
                     run_in   = {1'b0, max_run_ff};
                     phase_in = PH_RUN;
                  end else begin
                     exp_in  = sd0.exp_dir;
                     act_in  = sd0.act_dir;
                     if (sd0.clr) se_in = '0;
                     real_in = end_pos;
                     if (mode_ff == tpvac_pkg::MODE_FULL) begin
                        tps_in = $signed({{2{end_pos[21]}}, end_pos, 8'b0});
                        dem_in = '0;
                     end
                     work_in  = '0;
                     mode_in  = tpvac_pkg::MODE_NORMAL;
                     phase_in = PH_START;
                  end
               end
               PH_RUN: begin
                  if (!(stop || run_ff == '0)) begin
                     step_done = 1'b1;
                  end else if (resync) begin
                     mode_in   = tpvac_pkg::MODE_RESET;
                     phase_in  = PH_START;
                     step_done = 1'b1;
                  end else begin
                     exp_in = sd0.exp_dir;
                     act_in = sd0.act_dir;
                     if (sd0.clr) se_in = '0;
                     if (rc_sum < 24'sd0) begin
                        real_in = '0;
                     end else if (rc_sum > $signed({4'b0, full_ff})) begin
                        real_in = $signed({2'b00, full_ff});
                     end else begin
                        real_in = rc_sum[21:0];
                     end
                     phase_in = PH_REQ;
                  end
               end
               default: step_done = 1'b1;
            endcase
         end
         default: ;
      endcase
   end

   assign status.demand_nz = (dem_ff != 11'sd0);
   assign status.need_want = need_want;
   assign status.step_done = step_done;
   assign rsp_tdata        = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff        <= 20'd120000;
         min_open_ff    <= '0;
         min_run_ff     <= 16'd1000;
         max_run_ff     <= 14'd5000;
         pause_ff       <= 16'd10000;
         corr_ff        <= '0;
         mode_ff        <= tpvac_pkg::MODE_INIT;
         phase_ff       <= PH_START;
         req_dir_ff     <= 1'b0;
         exp_ff         <= 2'sd0;
         act_ff         <= 2'sd0;
         se_ff          <= '1;
         wait_ff        <= '0;
         run_ff         <= '0;
         tps_ff         <= '0;
         dem_ff         <= '0;
         real_ff        <= '0;
         work_ff        <= '0;
         saved_valid_ff <= 1'b0;
         saved_mode_ff  <= tpvac_pkg::MODE_INIT;
         saved_dir_ff   <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         phase_ff       <= phase_in;
         req_dir_ff     <= req_dir_in;
         exp_ff         <= exp_in;
         act_ff         <= act_in;
         se_ff          <= se_in;
         wait_ff        <= wait_in;
         run_ff         <= run_in;
         tps_ff         <= tps_in;
         dem_ff         <= dem_in;
         real_ff        <= real_in;
         work_ff        <= work_in;
         saved_valid_ff <= saved_valid_in;
         saved_mode_ff  <= saved_mode_in;
         saved_dir_ff   <= saved_dir_in;
         if (csr_we) begin
            unique case (csr_addr)
               tpvac_pkg::CSR_FULL_TRAVEL: full_ff     <= csr_wdata;
               tpvac_pkg::CSR_MIN_OPEN:    min_open_ff <= csr_wdata[18:0];
               tpvac_pkg::CSR_MIN_RUN:     min_run_ff  <= csr_wdata[15:0];
               tpvac_pkg::CSR_MAX_RUN:     max_run_ff  <= csr_wdata[13:0];
               tpvac_pkg::CSR_PAUSE:       pause_ff    <= csr_wdata[15:0];
               tpvac_pkg::CSR_RUN_CORR:    corr_ff     <= $signed(csr_wdata[16:0]);
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         raw_ff <= req_elapsed_ms;
      end
      if (cmd.op == tpvac_pkg::OP_MULA_TICK || cmd.op == tpvac_pkg::OP_MULA_WANT) begin
         m1_ff <= m1_prod;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (cmd.load_rsp) begin
         rsp_ff <= {3'b000, real_ff,
                    (mode_ff == tpvac_pkg::MODE_NORMAL) && (tps_ff == hi_tps),
                    (mode_ff == tpvac_pkg::MODE_NORMAL),
                    mode_ff,
                    (act_ff == 2'sd1),
                    (act_ff != 2'sd0)};
      end
   end

   `ASSERT_ALWAYS(a_force_saved, clock, reset, mode_ff != tpvac_pkg::MODE_FORCE || saved_valid_ff, "forced without saved mode")
   `ASSERT_ALWAYS(a_act_legal, clock, reset, act_ff != -2'sd2, "bad relay direction")

endmodule

/* hw/rtl/three_point_valve_actuator_controller.sv */
// Top level of the three-point valve actuator controller.
//
//   port group   dir   contents
//   req_*        in    action, elapsed time, demand, direction
//   rsp_*        out   relay states, mode, flags, position
//   csr_*        in    setting writes, index 0..5
//
// An event item goes from accept straight to its result. A tick with a nonzero
// demand runs the multiplier and the sequential 40-step divider; every tick then
// runs the apply step and up to 32 section steps, and each demand evaluation runs
// the multiplier and the divider again before its section step.
// Reset is synchronous; a waiting result does not block the next accept.
`timescale 1ns / 1ps

module three_point_valve_actuator_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [tpvac_pkg::REQ_DATA_W-1:0]     req_tdata,  // elapsed_ms, demand, move_up
   input  logic [tpvac_pkg::ACT_W-1:0]          req_tuser,  // action
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // relay_on, relay_plus, mode, is_ready, fully_open, position_ms
   output logic [tpvac_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_we,
   input  logic [tpvac_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [tpvac_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   tpvac_pkg::cmd_type    cmd;
   tpvac_pkg::status_type status;
   logic                  item_tick;

   assign item_tick = (req_tuser == tpvac_pkg::ACT_TICK) && (req_tdata[15:0] != '0);

   tpvac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .item_tick  (item_tick),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tpvac_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .req_action     (req_tuser),
      .req_elapsed_ms (req_tdata[15:0]),
      .req_demand     ($signed(req_tdata[26:16])),
      .req_move_up    (req_tdata[27]),
      .cmd            (cmd),
      .status         (status),
      .rsp_tdata      (rsp_tdata)
   );

endmodule
